[hdl/dps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual pattern stream search package
// Shared types, register indexes and helper functions for the search unit.
// ----------------------------------------------------------------------------
package dps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int POS_W       = 5;
    localparam int LEN_W       = 5;
    localparam int TIMEOUT_W   = 32;
    localparam int ELAPSED_W   = TIMEOUT_W + 1;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int BYTE_W      = 8;

    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [ELAPSED_W-1:0] elapsed_t;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OUT_TIMEOUT = 2'd0,
        OUT_FIRST   = 2'd1,
        OUT_SECOND  = 2'd2
    } outcome_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FIRST_LOW   = 3'd0,
        REG_FIRST_HIGH  = 3'd1,
        REG_SECOND_LOW  = 3'd2,
        REG_SECOND_HIGH = 3'd3,
        REG_FIRST_LEN   = 3'd4,
        REG_SECOND_LEN  = 3'd5,
        REG_SECOND_EN   = 3'd6,
        REG_TIMEOUT     = 3'd7
    } reg_index_t;

    // Lengths above the pattern storage are treated as the full pattern.
    function automatic len_t eff_len(input len_t len);
        if (len > len_t'(MAX_PATTERN)) begin
            return len_t'(MAX_PATTERN);
        end
        return len;
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_byte(
        input logic [63:0] lo,
        input logic [63:0] hi,
        input pos_t        pos
    );
        logic [127:0] word;
        word = {hi, lo};
        return word[{pos[3:0], 3'b000} +: BYTE_W];
    endfunction

    // Naive restart: a mismatch drops to zero without rechecking byte zero.
    function automatic pos_t advance(
        input pos_t              pos,
        input len_t              len,
        input logic [63:0]       lo,
        input logic [63:0]       hi,
        input logic [BYTE_W-1:0] rx
    );
        if (pos >= len) begin
            return pos;
        end
        if (pattern_byte(lo, hi, pos) == rx) begin
            return pos + pos_t'(1);
        end
        return '0;
    endfunction

endpackage

`default_nettype wire

[hdl/dual_pattern_stream_search_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// A result is registered onto the master side the cycle after its item is accepted.
// Throughput: one item per cycle unless the output stalls; the match positions and
// tick count update in one pass: two byte compares, a 33-bit increment and compare.
// Reset: synchronous, active low; clears the configuration registers, the search
// state and the output valid. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Dual pattern stream search unit
// Searches a byte stream for one of two configured patterns with a tick timeout.
// ----------------------------------------------------------------------------
module dual_pattern_stream_search_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write port.
    input  wire logic                              cfg_we,
    input  wire logic [dps_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [dps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Input items.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,  // [7:0] received_byte
    input  wire logic [1:0]                        s_tuser,  // [1:0] mode
    // Result items.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [7:0]                             m_tdata   // [1:0] outcome
);
    import dps_pkg::*;

    logic [63:0]          first_low_reg, first_high_reg;
    logic [63:0]          second_low_reg, second_high_reg;
    len_t                 first_len_reg, second_len_reg;
    logic                 second_en_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    logic     searching_reg, searching_next;
    pos_t     first_pos_reg, first_pos_next;
    pos_t     second_pos_reg, second_pos_next;
    elapsed_t elapsed_reg, elapsed_next;

    logic     out_valid_reg;
    outcome_t outcome_reg;

    logic     accept;
    logic     res_valid;
    outcome_t res_outcome;
    len_t     l1, l2;
    mode_t    mode;
    elapsed_t elapsed_inc;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, outcome_reg};

    assign l1   = eff_len(first_len_reg);
    assign l2   = eff_len(second_len_reg);
    assign mode = mode_t'(s_tuser);

    // The counter saturates; in practice it stops well before since the
    // timeout is at most 32 bits wide.
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + elapsed_t'(1);

    always_comb begin
        searching_next  = searching_reg;
        first_pos_next  = first_pos_reg;
        second_pos_next = second_pos_reg;
        elapsed_next    = elapsed_reg;
        res_valid       = 1'b0;
        res_outcome     = OUT_TIMEOUT;
        unique case (mode)
            MODE_START: begin
                searching_next  = 1'b1;
                first_pos_next  = '0;
                second_pos_next = '0;
                elapsed_next    = '0;
            end
            MODE_BYTE: begin
                if (searching_reg) begin
                    first_pos_next = advance(first_pos_reg, l1, first_low_reg,
                                             first_high_reg, s_tdata);
                    if (second_en_reg) begin
                        second_pos_next = advance(second_pos_reg, l2, second_low_reg,
                                                  second_high_reg, s_tdata);
                    end
                end
            end
            MODE_TICK: begin
                if (searching_reg) begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > {1'b0, timeout_reg}) begin
                        searching_next = 1'b0;
                        res_valid      = 1'b1;
                        res_outcome    = OUT_TIMEOUT;
                    end
                end
            end
            default: begin
            end
        endcase
        // Completion check after a start or a byte; the first pattern wins a tie.
        if (mode == MODE_START || (mode == MODE_BYTE && searching_reg)) begin
            if (first_pos_next >= l1) begin
                searching_next = 1'b0;
                res_valid      = 1'b1;
                res_outcome    = OUT_FIRST;
            end else if (second_en_reg && second_pos_next >= l2) begin
                searching_next = 1'b0;
                res_valid      = 1'b1;
                res_outcome    = OUT_SECOND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_low_reg   <= '0;
            first_high_reg  <= '0;
            second_low_reg  <= '0;
            second_high_reg <= '0;
            first_len_reg   <= '0;
            second_len_reg  <= '0;
            second_en_reg   <= 1'b0;
            timeout_reg     <= '0;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_addr))
                REG_FIRST_LOW:   first_low_reg   <= cfg_wdata;
                REG_FIRST_HIGH:  first_high_reg  <= cfg_wdata;
                REG_SECOND_LOW:  second_low_reg  <= cfg_wdata;
                REG_SECOND_HIGH: second_high_reg <= cfg_wdata;
                REG_FIRST_LEN:   first_len_reg   <= cfg_wdata[LEN_W-1:0];
                REG_SECOND_LEN:  second_len_reg  <= cfg_wdata[LEN_W-1:0];
                REG_SECOND_EN:   second_en_reg   <= cfg_wdata[0];
                REG_TIMEOUT:     timeout_reg     <= cfg_wdata[TIMEOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            searching_reg  <= 1'b0;
            first_pos_reg  <= '0;
            second_pos_reg <= '0;
            elapsed_reg    <= '0;
        end else if (accept) begin
            searching_reg  <= searching_next;
            first_pos_reg  <= first_pos_next;
            second_pos_reg <= second_pos_next;
            elapsed_reg    <= elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= accept && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            outcome_reg <= res_outcome;
        end
    end

    // Any item that produces a result also ends the search.
    a_result_ends_search: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res_valid |=> !searching_reg)
        else $error("search still active after a result");

    // Match positions never run past the pattern storage.
    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        first_pos_reg <= pos_t'(MAX_PATTERN) && second_pos_reg <= pos_t'(MAX_PATTERN))
        else $error("match position beyond pattern storage");

    // The input side only stalls behind a result that is waiting.
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a pending result");

endmodule

`default_nettype wire

[tb/dual_pattern_stream_search_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual pattern stream search unit testbench
// Sends start, byte and tick items against a range of pattern, length and
// timeout settings. A behavioral copy of the search predicts each outcome,
// and the result stream is checked in order. Both sides idle at random, and
// the output is held off for a long stretch once.
// ----------------------------------------------------------------------------
module dual_pattern_stream_search_unit_tb;
    import dps_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_ITEMS   = 55;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [7:0] received_byte
    logic [1:0]            s_tuser   = '0;   // [1:0] mode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;          // [1:0] outcome

    dual_pattern_stream_search_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Shadow of the configuration registers and the search state.
    logic [127:0]         first_pat  = '0;
    logic [127:0]         second_pat = '0;
    len_t                 first_len  = '0;
    len_t                 second_len = '0;
    logic                 second_on  = 1'b0;
    logic [TIMEOUT_W-1:0] tick_limit = '0;
    logic                 active     = 1'b0;
    pos_t                 first_at   = '0;
    pos_t                 second_at  = '0;
    elapsed_t             ticks_seen = '0;

    outcome_t    pending_outcomes[$];
    outcome_t    oldest_outcome;
    int unsigned mismatches      = 0;
    int unsigned items_counted   = 0;
    int unsigned results_checked = 0;
    int unsigned outcome_hits[3] = '{0, 0, 0};
    int unsigned quiet_cycles    = 0;
    int          hold_left       = 0;
    bit          hold_request    = 1'b0;
    bit          tx_idle_en      = 1'b1;
    bit          rx_idle_en      = 1'b1;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic len_t clip_len(input len_t l);
        return (l > len_t'(MAX_PATTERN)) ? len_t'(MAX_PATTERN) : l;
    endfunction

    // A mismatch drops back to zero; the byte is not tried against byte zero again.
    function automatic pos_t step_pos(input pos_t at, input len_t l,
                                      input logic [127:0] pat, input logic [7:0] rx);
        if (at >= clip_len(l)) begin
            return at;
        end
        if (pat[{at[3:0], 3'b000} +: 8] == rx) begin
            return at + pos_t'(1);
        end
        return '0;
    endfunction

    // The first pattern wins when both are complete.
    function automatic void check_done(output logic done, output outcome_t oc);
        done = 1'b0;
        oc   = OUT_TIMEOUT;
        if (first_at >= clip_len(first_len)) begin
            done = 1'b1;
            oc   = OUT_FIRST;
        end else if (second_on && second_at >= clip_len(second_len)) begin
            done = 1'b1;
            oc   = OUT_SECOND;
        end
        if (done) begin
            active = 1'b0;
        end
    endfunction

    function automatic void track_search(input mode_t m, input logic [7:0] rx,
                                         output logic produced, output outcome_t oc,
                                         output logic effective);
        produced  = 1'b0;
        oc        = OUT_TIMEOUT;
        effective = 1'b0;
        case (m)
            MODE_START: begin
                effective  = 1'b1;
                active     = 1'b1;
                first_at   = '0;
                second_at  = '0;
                ticks_seen = '0;
                check_done(produced, oc);
            end
            MODE_BYTE: begin
                if (active) begin
                    effective = 1'b1;
                    first_at  = step_pos(first_at, first_len, first_pat, rx);
                    if (second_on) begin
                        second_at = step_pos(second_at, second_len, second_pat, rx);
                    end
                    check_done(produced, oc);
                end
            end
            MODE_TICK: begin
                if (active) begin
                    effective = 1'b1;
                    if (ticks_seen != '1) begin
                        ticks_seen = ticks_seen + elapsed_t'(1);
                    end
                    if (ticks_seen > elapsed_t'(tick_limit)) begin
                        active   = 1'b0;
                        produced = 1'b1;
                        oc       = OUT_TIMEOUT;
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Keeps the low w bits of v and fills the rest of the bus with noise.
    function automatic logic [63:0] dressed(input logic [63:0] v, input int w);
        logic [63:0] keep;
        keep = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        return ({$urandom(), $urandom()} & ~keep) | (v & keep);
    endfunction

    function automatic len_t pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 6) begin
            return '0;
        end
        if (r < 12) begin
            return len_t'(MAX_PATTERN);
        end
        if (r < 18) begin
            return len_t'($urandom_range(31, MAX_PATTERN + 1));
        end
        return len_t'($urandom_range(1, 5));
    endfunction

    function automatic logic [31:0] pick_timeout();
        case ($urandom_range(4))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom();
            default: return $urandom_range(1, 25);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t ns", what, got, want, $time);
        mismatches++;
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [63:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FIRST_LOW:   first_pat[63:0]    = v;
            REG_FIRST_HIGH:  first_pat[127:64]  = v;
            REG_SECOND_LOW:  second_pat[63:0]   = v;
            REG_SECOND_HIGH: second_pat[127:64] = v;
            REG_FIRST_LEN:   first_len          = v[LEN_W-1:0];
            REG_SECOND_LEN:  second_len         = v[LEN_W-1:0];
            REG_SECOND_EN:   second_on          = v[0];
            REG_TIMEOUT:     tick_limit         = v[TIMEOUT_W-1:0];
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    task automatic configure(input logic [63:0] lo1, input logic [63:0] hi1,
                             input logic [63:0] lo2, input logic [63:0] hi2,
                             input len_t l1, input len_t l2, input logic en,
                             input logic [31:0] limit);
        write_reg(REG_FIRST_LOW, lo1);
        write_reg(REG_FIRST_HIGH, hi1);
        write_reg(REG_SECOND_LOW, lo2);
        write_reg(REG_SECOND_HIGH, hi2);
        write_reg(REG_FIRST_LEN, dressed(64'(l1), LEN_W));
        write_reg(REG_SECOND_LEN, dressed(64'(l2), LEN_W));
        write_reg(REG_SECOND_EN, dressed(64'(en), 1));
        write_reg(REG_TIMEOUT, dressed(64'(limit), TIMEOUT_W));
    endtask

    // Offers one item, waits for it to be taken and records what it should cause.
    task automatic push_item(input mode_t m, input logic [7:0] rx);
        logic     produced;
        logic     effective;
        outcome_t oc;
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= rx;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        track_search(m, rx, produced, oc, effective);
        if (produced) begin
            pending_outcomes.push_back(oc);
        end
        if (effective) begin
            items_counted++;
        end
        if (tx_idle_en && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // The sender stays quiet until every expected result has come back.
    task automatic finish_pending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_outcomes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_idle_defaults();
        // After reset every register is zero, so the first pattern is empty.
        push_item(MODE_BYTE, 8'hFF);
        push_item(MODE_NONE, 8'hA5);
        push_item(MODE_START, 8'h00);
        finish_pending();
    endtask

    task automatic test_full_length();
        // A length above the pattern storage behaves as the full sixteen bytes.
        configure(64'h0123_4567_89AB_CDEF, 64'hFF00_7E81_C33C_A55A, '1, '1,
                  5'd31, len_t'(MAX_PATTERN), 1'b0, 32'hFFFF_FFFF);
        push_item(MODE_START, 8'($urandom()));
        for (int i = 0; i < MAX_PATTERN; i++) begin
            push_item(MODE_BYTE, first_pat[i*8 +: 8]);
        end
        finish_pending();
    endtask

    task automatic test_tie_and_empty_second();
        configure(64'h0000_0000_0077_C35A, '0, 64'h0000_0000_0011_C35A, '0,
                  5'd2, 5'd2, 1'b1, 32'd10);
        push_item(MODE_START, 8'h00);
        push_item(MODE_BYTE, 8'h5A);
        push_item(MODE_BYTE, 8'hC3);
        finish_pending();
        write_reg(REG_SECOND_LEN, dressed(64'd0, LEN_W));
        push_item(MODE_START, 8'h00);
        finish_pending();
    endtask

    task automatic test_timeout_and_restart();
        write_reg(REG_SECOND_LEN, dressed(64'd2, LEN_W));
        write_reg(REG_TIMEOUT, dressed(64'd0, TIMEOUT_W));
        push_item(MODE_START, 8'h00);
        push_item(MODE_START, 8'hFF);
        push_item(MODE_TICK, 8'h3C);
        finish_pending();
    endtask

    task automatic test_length_lowered();
        write_reg(REG_FIRST_LEN, dressed(64'd3, LEN_W));
        write_reg(REG_SECOND_LEN, dressed(64'd3, LEN_W));
        write_reg(REG_TIMEOUT, dressed(64'hFFFF_FFFF, TIMEOUT_W));
        push_item(MODE_START, 8'h00);
        push_item(MODE_BYTE, 8'h5A);
        push_item(MODE_BYTE, 8'hC3);
        finish_pending();
        // The first position already passes the new length, so any byte ends it.
        write_reg(REG_FIRST_LEN, dressed(64'd1, LEN_W));
        push_item(MODE_BYTE, 8'h00);
        finish_pending();
    endtask

    task automatic test_output_stall();
        tx_idle_en = 1'b0;
        write_reg(REG_FIRST_LEN, dressed(64'd0, LEN_W));
        hold_request = 1'b1;
        repeat (16) push_item(MODE_START, 8'($urandom()));
        finish_pending();
        tx_idle_en = 1'b1;
    endtask

    task automatic random_phase(input int unsigned target);
        logic [7:0]  alpha[2];
        logic [63:0] words[4];
        logic [7:0]  rx;
        bit          narrow;
        int unsigned stop_at;
        int          r;
        // Narrow phases draw everything from two byte values, so repeated bytes
        // exercise the naive restart.
        narrow   = ($urandom_range(2) == 0);
        alpha[0] = 8'($urandom());
        alpha[1] = 8'($urandom());
        for (int w = 0; w < 4; w++) begin
            words[w] = {$urandom(), $urandom()};
            if (narrow) begin
                for (int k = 0; k < 8; k++) begin
                    words[w][k*8 +: 8] = alpha[$urandom_range(1)];
                end
            end
        end
        configure(words[0], words[1], words[2], words[3], pick_len(), pick_len(),
                  1'($urandom_range(1)), pick_timeout());
        stop_at = items_counted + target;
        while (items_counted < stop_at) begin
            r  = $urandom_range(99);
            rx = narrow ? alpha[$urandom_range(1)] : 8'($urandom());
            if (!active) begin
                if (r < 6) begin
                    push_item((r < 3) ? MODE_BYTE : MODE_TICK, rx);
                end else begin
                    push_item(MODE_START, rx);
                end
            end else if (r < 3) begin
                push_item(MODE_START, rx);
            end else if (r < 11) begin
                push_item(MODE_TICK, rx);
            end else if (r < 14) begin
                push_item(MODE_NONE, rx);
            end else if (r < 30) begin
                push_item(MODE_BYTE, rx);
            end else if (second_on && r < 65) begin
                push_item(MODE_BYTE, second_pat[{second_at[3:0], 3'b000} +: 8]);
            end else begin
                push_item(MODE_BYTE, first_pat[{first_at[3:0], 3'b000} +: 8]);
            end
        end
        finish_pending();
    endtask

    task automatic test_random_search();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            // Two phases run back to back with no idling on either side.
            tx_idle_en = !(p == 4 || p == 5);
            rx_idle_en = tx_idle_en;
            random_phase(PHASE_ITEMS);
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Result side: random ready, with one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(99) < 13) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (m_tdata[1:0] <= OUT_SECOND) begin
                outcome_hits[m_tdata[1:0]]++;
            end
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result with none expected", m_tdata, 8'h00);
            end else begin
                oldest_outcome = pending_outcomes.pop_front();
                if (m_tdata[1:0] != oldest_outcome) begin
                    report_mismatch("outcome", 8'(m_tdata[1:0]), 8'(oldest_outcome));
                end
                if (m_tdata[7:2] != '0) begin
                    report_mismatch("tdata padding", 8'(m_tdata[7:2]), 8'h00);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_outcomes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_defaults();
        test_full_length();
        test_tie_and_empty_second();
        test_timeout_and_restart();
        test_length_lowered();
        test_output_stall();
        test_random_search();
        $display("Covered %0d search items over %0d pattern settings, lengths 0 to 31.",
                 items_counted, RANDOM_PHASES + 2);
        $display("Checked %0d results: %0d timeouts, %0d first, %0d second pattern hits.",
                 results_checked, outcome_hits[OUT_TIMEOUT], outcome_hits[OUT_FIRST],
                 outcome_hits[OUT_SECOND]);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
